// ===== design/cmsd_pkg.sv =====
// Shared types and constants for the compact map stream decoder.
package cmsd_pkg;

    typedef enum logic [15:0] {
        PH_BLOCKS = 16'h0001,
        PH_COLOUR = 16'h0002,
        PH_NRECT  = 16'h0004,
        PH_RECT   = 16'h0008,
        PH_NPAT   = 16'h0010,
        PH_PW     = 16'h0020,
        PH_PH     = 16'h0040,
        PH_PIX    = 16'h0080,
        PH_NSPOT  = 16'h0100,
        PH_SX     = 16'h0200,
        PH_SY     = 16'h0400,
        PH_NROWS  = 16'h0800,
        PH_NRUNS  = 16'h1000,
        PH_TRANS  = 16'h2000,
        PH_OPQ    = 16'h4000,
        PH_RPIX   = 16'h8000
    } t_phase;

    localparam logic [2:0] KIND_RECT  = 3'd0;
    localparam logic [2:0] KIND_PIXEL = 3'd1;
    localparam logic [2:0] KIND_PLACE = 3'd2;
    localparam logic [2:0] KIND_RUN   = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    localparam logic [16:0] RUN_X_MAX = 17'h1FFFF;
    localparam int          QDEPTH    = 4;
    localparam int          QAW       = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [16:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] size_w;
        logic [15:0] size_h;
        logic [15:0] pattern_number;
        logic        last;
    } t_cmd;

endpackage

// ===== design/cmsd_front.sv =====
// Front end: parses stream bytes and forms drawing commands.
module cmsd_front
    import cmsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);
    t_phase      r_phase, n_phase;
    logic [1:0]  r_esc, n_esc;
    logic [7:0]  r_wlo, n_wlo;
    logic [7:0]  r_blocks, n_blocks;
    logic [7:0]  r_colour, n_colour;
    logic [15:0] r_rects, n_rects;
    logic [1:0]  r_rfi, n_rfi;
    logic [23:0] r_rbytes, n_rbytes;
    logic [15:0] r_pats, n_pats;
    logic [15:0] r_pidx, n_pidx;
    logic [15:0] r_pw, n_pw;
    logic [15:0] r_ph, n_ph;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [15:0] r_spots, n_spots;
    logic [7:0]  r_sx, n_sx;
    logic [15:0] r_rows, n_rows;
    logic [15:0] r_ridx, n_ridx;
    logic [7:0]  r_runs, n_runs;
    logic [16:0] r_rx, n_rx;
    logic [8:0]  r_opq, n_opq;

    logic        cnt_done;
    logic [15:0] cnt_val;
    logic [17:0] sum_t, sum_1;
    logic [16:0] sat_t, sat_1;
    logic [15:0] col_inc, row_inc, rows_dec;
    logic        map_end;
    logic        emit;
    t_cmd        cmd;

    always_comb begin
        cnt_done = 1'b0;
        cnt_val  = {8'd0, i_byte};
        if (r_esc == 2'd2) begin
            cnt_done = 1'b1;
            cnt_val  = {i_byte, r_wlo};
        end else if (r_esc == 2'd0 && i_byte != 8'd0) begin
            cnt_done = 1'b1;
        end
    end

    assign sum_t    = {1'b0, r_rx} + {10'd0, i_byte};
    assign sat_t    = sum_t > {1'b0, RUN_X_MAX} ? RUN_X_MAX : sum_t[16:0];
    assign sum_1    = {1'b0, r_rx} + 18'd1;
    assign sat_1    = sum_1 > {1'b0, RUN_X_MAX} ? RUN_X_MAX : sum_1[16:0];
    assign col_inc  = r_col + 16'd1;
    assign row_inc  = r_row + 16'd1;
    assign rows_dec = r_rows - 16'd1;

    always_comb begin
        n_phase = r_phase; n_esc = r_esc; n_wlo = r_wlo; n_blocks = r_blocks;
        n_colour = r_colour; n_rects = r_rects; n_rfi = r_rfi; n_rbytes = r_rbytes;
        n_pats = r_pats; n_pidx = r_pidx; n_pw = r_pw; n_ph = r_ph;
        n_col = r_col; n_row = r_row; n_spots = r_spots; n_sx = r_sx;
        n_rows = r_rows; n_ridx = r_ridx; n_runs = r_runs; n_rx = r_rx;
        n_opq = r_opq;
        map_end = 1'b0;
        emit    = 1'b0;
        cmd     = '0;

        // count reader shared by the escaped count phases (NRECT, NPAT, PW, PH, NSPOT, NROWS)
        if (r_phase == PH_NRECT || r_phase == PH_NPAT || r_phase == PH_PW
            || r_phase == PH_PH || r_phase == PH_NSPOT || r_phase == PH_NROWS) begin
            if (r_esc == 2'd1) begin
                n_wlo = i_byte;
                n_esc = 2'd2;
            end else if (r_esc == 2'd2) begin
                n_esc = 2'd0;
            end else if (i_byte == 8'd0) begin
                n_esc = 2'd1;
            end
        end

        unique case (r_phase)
            PH_BLOCKS: begin
                n_blocks = i_byte;
                n_phase  = (i_byte == 8'd0) ? PH_NPAT : PH_COLOUR;
            end
            PH_COLOUR: begin
                n_colour = i_byte;
                n_phase  = PH_NRECT;
            end
            PH_NRECT: begin
                if (cnt_done) begin
                    n_rects = cnt_val;
                    n_rfi   = 2'd0;
                    if (cnt_val == 16'd0) begin
                        n_blocks = r_blocks - 8'd1;
                        n_phase  = (r_blocks == 8'd1) ? PH_NPAT : PH_COLOUR;
                    end else begin
                        n_phase = PH_RECT;
                    end
                end
            end
            PH_RECT: begin
                if (r_rfi != 2'd3) begin
                    unique case (r_rfi)
                        2'd0:    n_rbytes[7:0]   = i_byte;
                        2'd1:    n_rbytes[15:8]  = i_byte;
                        default: n_rbytes[23:16] = i_byte;
                    endcase
                    n_rfi = r_rfi + 2'd1;
                end else begin
                    emit         = 1'b1;
                    cmd.kind     = KIND_RECT;
                    cmd.value    = r_colour;
                    cmd.pos_x    = {9'd0, r_rbytes[7:0]};
                    cmd.pos_y    = {8'd0, r_rbytes[15:8]};
                    cmd.size_w   = {8'd0, r_rbytes[23:16]} + 16'd1;
                    cmd.size_h   = {8'd0, i_byte} + 16'd1;
                    n_rfi        = 2'd0;
                    n_rects      = r_rects - 16'd1;
                    if (r_rects == 16'd1) begin
                        n_blocks = r_blocks - 8'd1;
                        n_phase  = (r_blocks == 8'd1) ? PH_NPAT : PH_COLOUR;
                    end
                end
            end
            PH_NPAT: begin
                if (cnt_done) begin
                    n_pats  = cnt_val;
                    n_pidx  = 16'd0;
                    n_phase = (cnt_val == 16'd0) ? PH_NROWS : PH_PW;
                end
            end
            PH_PW: begin
                if (cnt_done) begin
                    n_pw    = cnt_val;
                    n_phase = PH_PH;
                end
            end
            PH_PH: begin
                if (cnt_done) begin
                    n_ph    = cnt_val;
                    n_col   = 16'd0;
                    n_row   = 16'd0;
                    n_phase = (r_pw == 16'd0 || cnt_val == 16'd0) ? PH_NSPOT : PH_PIX;
                end
            end
            PH_PIX: begin
                emit               = 1'b1;
                cmd.kind           = KIND_PIXEL;
                cmd.value          = i_byte;
                cmd.pos_x          = {1'b0, r_col};
                cmd.pos_y          = r_row;
                cmd.pattern_number = r_pidx;
                n_col              = col_inc;
                if (col_inc >= r_pw) begin
                    n_col = 16'd0;
                    n_row = row_inc;
                    if (row_inc >= r_ph) n_phase = PH_NSPOT;
                end
            end
            PH_NSPOT: begin
                if (cnt_done) begin
                    n_spots = cnt_val;
                    if (cnt_val == 16'd0) begin
                        n_pidx  = r_pidx + 16'd1;
                        n_pats  = r_pats - 16'd1;
                        n_phase = (r_pats == 16'd1) ? PH_NROWS : PH_PW;
                    end else begin
                        n_phase = PH_SX;
                    end
                end
            end
            PH_SX: begin
                n_sx    = i_byte;
                n_phase = PH_SY;
            end
            PH_SY: begin
                emit               = 1'b1;
                cmd.kind           = KIND_PLACE;
                cmd.pos_x          = {9'd0, r_sx};
                cmd.pos_y          = {8'd0, i_byte};
                cmd.size_w         = r_pw;
                cmd.size_h         = r_ph;
                cmd.pattern_number = r_pidx;
                n_spots            = r_spots - 16'd1;
                if (r_spots == 16'd1) begin
                    n_pidx  = r_pidx + 16'd1;
                    n_pats  = r_pats - 16'd1;
                    n_phase = (r_pats == 16'd1) ? PH_NROWS : PH_PW;
                end else begin
                    n_phase = PH_SX;
                end
            end
            PH_NROWS: begin
                if (cnt_done) begin
                    n_rows = cnt_val;
                    n_ridx = 16'd0;
                    if (cnt_val == 16'd0) map_end = 1'b1;
                    else n_phase = PH_NRUNS;
                end
            end
            PH_NRUNS: begin
                n_runs = i_byte;
                n_rx   = 17'd0;
                if (i_byte == 8'd0) begin
                    n_ridx = r_ridx + 16'd1;
                    n_rows = rows_dec;
                    if (rows_dec == 16'd0) map_end = 1'b1;
                    else n_phase = PH_NRUNS;
                end else begin
                    n_phase = PH_TRANS;
                end
            end
            PH_TRANS: begin
                n_rx    = sat_t;
                n_phase = PH_OPQ;
            end
            PH_OPQ: begin
                n_opq   = {1'b0, i_byte} + 9'd1;
                n_phase = PH_RPIX;
            end
            PH_RPIX: begin
                emit      = 1'b1;
                cmd.kind  = KIND_RUN;
                cmd.value = i_byte;
                cmd.pos_x = r_rx;
                cmd.pos_y = r_ridx;
                n_rx      = sat_1;
                n_opq     = r_opq - 9'd1;
                if (r_opq == 9'd1) begin
                    n_runs = r_runs - 8'd1;
                    if (r_runs == 8'd1) begin
                        n_ridx = r_ridx + 16'd1;
                        n_rows = rows_dec;
                        if (rows_dec == 16'd0) map_end = 1'b1;
                        else n_phase = PH_NRUNS;
                    end else begin
                        n_phase = PH_TRANS;
                    end
                end
            end
            default: n_phase = PH_BLOCKS;
        endcase

        if (map_end) begin
            if (!emit) begin
                cmd      = '0;
                cmd.kind = KIND_END;
            end
            emit     = 1'b1;
            cmd.last = 1'b1;
            n_phase  = PH_BLOCKS;
            n_esc    = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLOCKS; r_esc <= '0; r_wlo <= '0; r_blocks <= '0;
            r_colour <= '0; r_rects <= '0; r_rfi <= '0; r_rbytes <= '0;
            r_pats <= '0; r_pidx <= '0; r_pw <= '0; r_ph <= '0;
            r_col <= '0; r_row <= '0; r_spots <= '0; r_sx <= '0;
            r_rows <= '0; r_ridx <= '0; r_runs <= '0; r_rx <= '0; r_opq <= '0;
            o_cmd_valid <= 1'b0;
        end else begin
            o_cmd_valid <= i_valid && emit;
            if (i_valid) begin
                r_phase <= n_phase; r_esc <= n_esc; r_wlo <= n_wlo;
                r_blocks <= n_blocks; r_colour <= n_colour; r_rects <= n_rects;
                r_rfi <= n_rfi; r_rbytes <= n_rbytes; r_pats <= n_pats;
                r_pidx <= n_pidx; r_pw <= n_pw; r_ph <= n_ph; r_col <= n_col;
                r_row <= n_row; r_spots <= n_spots; r_sx <= n_sx;
                r_rows <= n_rows; r_ridx <= n_ridx; r_runs <= n_runs;
                r_rx <= n_rx; r_opq <= n_opq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_cmd <= cmd;
    end
endmodule

// ===== design/cmsd_queue.sv =====
// Command queue between the parser and the result port.
module cmsd_queue
    import cmsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    input  logic i_rd,
    output logic o_empty,
    output logic o_room,
    output t_cmd o_cmd
);
    t_cmd          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           rd_ok;

    assign rd_ok   = i_rd && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    // two free entries cover the result of the item now in the parser register
    assign o_room  = ({1'b0, r_cnt} + {{(QAW+1){1'b0}}, i_wr} + (QAW+2)'(2))
                     <= (QAW+2)'(QDEPTH);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (rd_ok) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_wr) - (QAW+1)'(rd_ok);
        end
    end
endmodule

// ===== design/compact_map_stream_decoder.sv =====
// Top level of the compact map stream decoder.
// Input channel: one stream byte per transaction on i_data_byte, taken at a
// clock edge where push is high and full is low.
// Result channel: a drawing command waits on the o_* fields while empty is
// low and is taken at an edge where pop is high.
// A byte that only updates parser state makes no result; any other byte makes
// exactly one, in stream order. The final byte of a map sets o_last.
// Each result is held first in the parser register, then in the queue, before
// it is visible. Throughput: one byte per cycle while full is low, as the
// parser updates its phase on every accepted byte.
// A four-entry queue absorbs receiver stalls; full rises when fewer than two
// entries would be free after the write now arriving, so no result is lost.
// Synchronous active-low reset returns the parser to the start of a map and
// empties the queue; no clearing pass is needed.
module compact_map_stream_decoder
    import cmsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_value,
    output logic [16:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_size_w,
    output logic [15:0] o_size_h,
    output logic [15:0] o_pattern_number,
    output logic        o_last
);
    logic cmd_valid, room, acc;
    t_cmd cmd, head;

    assign full = !room;
    assign acc  = push && room;

    cmsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_byte(i_data_byte),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd)
    );

    cmsd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(cmd_valid), .i_cmd(cmd),
        .i_rd(pop), .o_empty(empty), .o_room(room), .o_cmd(head)
    );

    assign o_kind           = head.kind;
    assign o_value          = head.value;
    assign o_pos_x          = head.pos_x;
    assign o_pos_y          = head.pos_y;
    assign o_size_w         = head.size_w;
    assign o_size_h         = head.size_h;
    assign o_pattern_number = head.pattern_number;
    assign o_last           = head.last;
endmodule
